// ===== rtl/tbg_pkg.sv =====
// Package for the tetrahedron barycentric gradient block.
// Shared types, fixed widths and saturation constants. No dependencies.
package tbg_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int IN_W       = COORD_WIDTH;
    localparam int OUT_W      = 48;
    localparam int COORD_FRAC = 16;
    localparam int OUT_FRAC   = 24;
    localparam int GRAD_SH    = COORD_FRAC + OUT_FRAC;
    localparam int MUL_CHUNK  = 16;
    localparam int NLANE      = 4;
    localparam int LANE_C     = 3;

    localparam logic [1:0]       VSEL_LAST = 2'd3;
    localparam logic [OUT_W-1:0] SAT_POS   = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] SAT_NEG   = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic signed [IN_W-1:0] v0_x;
        logic signed [IN_W-1:0] v0_y;
        logic signed [IN_W-1:0] v0_z;
        logic signed [IN_W-1:0] v1_x;
        logic signed [IN_W-1:0] v1_y;
        logic signed [IN_W-1:0] v1_z;
        logic signed [IN_W-1:0] v2_x;
        logic signed [IN_W-1:0] v2_y;
        logic signed [IN_W-1:0] v2_z;
        logic signed [IN_W-1:0] v3_x;
        logic signed [IN_W-1:0] v3_y;
        logic signed [IN_W-1:0] v3_z;
    } t_in;

    typedef struct packed {
        logic [1:0]              vertex_sel;
        logic signed [OUT_W-1:0] grad_x;
        logic signed [OUT_W-1:0] grad_y;
        logic signed [OUT_W-1:0] grad_z;
        logic signed [OUT_W-1:0] const_term;
        logic                    degenerate;
        logic                    last;
    } t_out;

    typedef struct packed {
        logic [1:0] vsel;
        logic       last;
    } t_side;

endpackage

// ===== rtl/tet_barycentric_gradients.sv =====
// Top level: tetrahedron barycentric coordinate gradients.
// Row serializer feeding tbg_geom and tbg_div. Uses tbg_pkg.
//
//   channel  direction  handshake                      payload
//   in       input      i_in_valid / o_in_ready        i_in  (t_in, one tetrahedron)
//   out      output     o_out_valid / i_out_ready      o_out (t_out, one vertex row)
//
// Each transaction on in yields four rows on out, vertex 0 to 3. One row
// enters the row pipeline per cycle while out does not stall; a new transaction
// is taken when idle or as the last row enters, the serializer sharing one
// geometry pipeline and one 4-lane divider. Synchronous active-low reset clears
// the busy flag, row counter and valid bits only. A stall on out freezes the
// whole pipeline; the input register still takes a transaction when empty.
module tet_barycentric_gradients (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tbg_pkg::t_in   i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output tbg_pkg::t_out  o_out
);
    import tbg_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int EXW  = (CW > IN_W) ? CW : IN_W;
    localparam int GW   = 2 * CW + 3;
    localparam int DETW = 3 * CW + 6;
    localparam int ATW  = 3 * CW + 5;

    logic                  r_busy;
    logic [1:0]            r_cnt;
    logic signed [CW-1:0]  r_pts [4][3];
    logic                  w_adv;
    logic                  w_acc;
    logic [1:0]            w_iq;
    logic [1:0]            w_ir;
    logic [1:0]            w_is;
    t_side                 w_side;
    logic                  w_gv;
    t_side                 w_gside;
    logic signed [GW-1:0]  w_g [3];
    logic signed [DETW-1:0] w_det;
    logic signed [ATW-1:0] w_a;
    logic                  w_ov;

    function automatic logic signed [CW-1:0] f_coord(input logic [IN_W-1:0] raw);
        logic [EXW-1:0] ext;
        ext = EXW'(raw);
        return ext[CW-1:0];
    endfunction

    assign w_adv      = !w_ov || i_out_ready;
    assign o_in_ready = !r_busy || (w_adv && (r_cnt == VSEL_LAST));
    assign w_acc      = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy && w_adv) begin
            r_cnt <= r_cnt + 2'd1;
            if (r_cnt == VSEL_LAST) r_busy <= w_acc;
        end else if (w_acc) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_pts[0][0] <= f_coord(i_in.v0_x);
            r_pts[0][1] <= f_coord(i_in.v0_y);
            r_pts[0][2] <= f_coord(i_in.v0_z);
            r_pts[1][0] <= f_coord(i_in.v1_x);
            r_pts[1][1] <= f_coord(i_in.v1_y);
            r_pts[1][2] <= f_coord(i_in.v1_z);
            r_pts[2][0] <= f_coord(i_in.v2_x);
            r_pts[2][1] <= f_coord(i_in.v2_y);
            r_pts[2][2] <= f_coord(i_in.v2_z);
            r_pts[3][0] <= f_coord(i_in.v3_x);
            r_pts[3][1] <= f_coord(i_in.v3_y);
            r_pts[3][2] <= f_coord(i_in.v3_z);
        end
    end

    assign w_iq        = r_cnt + 2'd1;
    assign w_ir        = r_cnt + 2'd2;
    assign w_is        = r_cnt + 2'd3;
    assign w_side.vsel = r_cnt;
    assign w_side.last = (r_cnt == VSEL_LAST);

    tbg_geom #(.CW(CW)) u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_busy),
        .i_side  (w_side),
        .i_p     (r_pts[r_cnt]),
        .i_q     (r_pts[w_iq]),
        .i_r     (r_pts[w_ir]),
        .i_s     (r_pts[w_is]),
        .o_valid (w_gv),
        .o_side  (w_gside),
        .o_g     (w_g),
        .o_det   (w_det),
        .o_a     (w_a)
    );

    tbg_div #(.CW(CW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_gv),
        .i_side  (w_gside),
        .i_g     (w_g),
        .i_det   (w_det),
        .i_a     (w_a),
        .o_valid (w_ov),
        .o_row   (o_out)
    );

    assign o_out_valid = w_ov;

`ifndef ASSERT_OFF
    a_acc_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> (r_busy && (r_cnt == 2'd0)))
        else $error("serializer not reloaded after input transaction");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_adv && r_busy) |=> $stable(r_cnt))
        else $error("row counter moved during stall");

    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.last) |-> (o_out.vertex_sel == VSEL_LAST))
        else $error("last flag on wrong vertex row");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.degenerate) |->
        ((o_out.grad_x == '0) && (o_out.grad_y == '0) &&
         (o_out.grad_z == '0) && (o_out.const_term == '0)))
        else $error("degenerate row with nonzero result");
`endif

endmodule

// ===== rtl/tbg_mul.sv =====
// Two-stage signed multiplier: operand b cut into 16-bit chunks, partial
// products registered, then summed and registered. Uses tbg_pkg.
module tbg_mul #(
    parameter int AW = 33,
    parameter int BW = 33
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [AW-1:0]     i_a,
    input  logic signed [BW-1:0]     i_b,
    output logic signed [AW+BW-1:0]  o_p
);
    import tbg_pkg::*;

    localparam int NC  = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int BXW = NC * MUL_CHUNK;
    localparam int PPW = AW + MUL_CHUNK + 1;
    localparam int PW  = AW + BW;

    logic signed [BXW-1:0] bx;
    logic signed [PPW-1:0] n_pp [NC];
    logic signed [PPW-1:0] r_pp [NC];
    logic signed [PW-1:0]  n_p;
    logic signed [PW-1:0]  r_p;

    assign bx = BXW'(i_b);

    always_comb begin
        logic signed [MUL_CHUNK:0] c;
        c = '0;
        for (int k = 0; k < NC; k++) begin
            if (k == NC - 1) begin
                c = {bx[k*MUL_CHUNK+MUL_CHUNK-1], bx[k*MUL_CHUNK +: MUL_CHUNK]};
            end else begin
                c = {1'b0, bx[k*MUL_CHUNK +: MUL_CHUNK]};
            end
            n_pp[k] = PPW'(i_a) * PPW'(c);
        end
    end

    always_comb begin
        n_p = '0;
        for (int k = 0; k < NC; k++) begin
            n_p = n_p + (PW'(r_pp[k]) <<< (k * MUL_CHUNK));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp <= n_pp;
            r_p  <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

// ===== rtl/tbg_geom.sv =====
// Row geometry pipeline: edge vectors, cross product, row determinant and
// constant numerator, seven register stages. Uses tbg_pkg and tbg_mul.
module tbg_geom #(
    parameter int CW = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  tbg_pkg::t_side            i_side,
    input  logic signed [CW-1:0]      i_p [3],
    input  logic signed [CW-1:0]      i_q [3],
    input  logic signed [CW-1:0]      i_r [3],
    input  logic signed [CW-1:0]      i_s [3],
    output logic                      o_valid,
    output tbg_pkg::t_side            o_side,
    output logic signed [2*CW+2:0]    o_g [3],
    output logic signed [3*CW+5:0]    o_det,
    output logic signed [3*CW+4:0]    o_a
);
    import tbg_pkg::*;

    localparam int DW   = CW + 1;
    localparam int GW   = 2 * DW + 1;
    localparam int DETW = GW + DW + 2;
    localparam int ATW  = GW + CW + 2;
    localparam int LAT  = 7;

    logic [LAT-1:0]         r_vld;
    t_side                  r_side [LAT];
    logic signed [DW-1:0]   r_u [3];
    logic signed [DW-1:0]   r_v [3];
    logic signed [DW-1:0]   r_w [3];
    logic signed [CW-1:0]   r_q [3];
    logic signed [DW-1:0]   r_wd [3][3];
    logic signed [CW-1:0]   r_qd [3][3];
    logic signed [2*DW-1:0] w_pa [3];
    logic signed [2*DW-1:0] w_pb [3];
    logic signed [GW-1:0]   r_g [3];
    logic signed [GW-1:0]   r_gd [3][3];
    logic signed [GW+DW-1:0] w_pd [3];
    logic signed [GW+CW-1:0] w_pq [3];
    logic signed [DETW-1:0] r_det;
    logic signed [ATW-1:0]  r_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int j = 1; j < LAT; j++) r_side[j] <= r_side[j-1];
            for (int k = 0; k < 3; k++) begin
                r_u[k] <= DW'(i_r[k]) - DW'(i_q[k]);
                r_v[k] <= DW'(i_s[k]) - DW'(i_q[k]);
                r_w[k] <= DW'(i_p[k]) - DW'(i_q[k]);
                r_q[k] <= i_q[k];
                r_wd[0][k] <= r_w[k];
                r_qd[0][k] <= r_q[k];
                for (int j = 1; j < 3; j++) begin
                    r_wd[j][k] <= r_wd[j-1][k];
                    r_qd[j][k] <= r_qd[j-1][k];
                end
                r_g[k] <= GW'(w_pa[k]) - GW'(w_pb[k]);
                r_gd[0][k] <= r_g[k];
                for (int j = 1; j < 3; j++) r_gd[j][k] <= r_gd[j-1][k];
            end
            r_det <= DETW'(w_pd[0]) + DETW'(w_pd[1]) + DETW'(w_pd[2]);
            r_a   <= ATW'(w_pq[0]) + ATW'(w_pq[1]) + ATW'(w_pq[2]);
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_comp
        tbg_mul #(.AW(DW), .BW(DW)) u_mul_a (
            .i_clk(i_clk), .i_en(i_en),
            .i_a(r_u[(k+1)%3]), .i_b(r_v[(k+2)%3]), .o_p(w_pa[k])
        );
        tbg_mul #(.AW(DW), .BW(DW)) u_mul_b (
            .i_clk(i_clk), .i_en(i_en),
            .i_a(r_u[(k+2)%3]), .i_b(r_v[(k+1)%3]), .o_p(w_pb[k])
        );
        tbg_mul #(.AW(GW), .BW(DW)) u_mul_d (
            .i_clk(i_clk), .i_en(i_en),
            .i_a(r_g[k]), .i_b(r_wd[2][k]), .o_p(w_pd[k])
        );
        tbg_mul #(.AW(GW), .BW(CW)) u_mul_q (
            .i_clk(i_clk), .i_en(i_en),
            .i_a(r_g[k]), .i_b(r_qd[2][k]), .o_p(w_pq[k])
        );
        assign o_g[k] = r_gd[2][k];
    end

    assign o_valid = r_vld[LAT-1];
    assign o_side  = r_side[LAT-1];
    assign o_det   = r_det;
    assign o_a     = r_a;

endmodule

// ===== rtl/tbg_div.sv =====
// Four-lane pipelined restoring divider, one quotient bit per stage, with
// round-to-nearest, saturation and output register. Uses tbg_pkg.
module tbg_div #(
    parameter int CW = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  tbg_pkg::t_side          i_side,
    input  logic signed [2*CW+2:0]  i_g [3],
    input  logic signed [3*CW+5:0]  i_det,
    input  logic signed [3*CW+4:0]  i_a,
    output logic                    o_valid,
    output tbg_pkg::t_out           o_row
);
    import tbg_pkg::*;

    localparam int GW   = 2 * CW + 3;
    localparam int DETW = 3 * CW + 6;
    localparam int ATW  = 3 * CW + 5;
    localparam int MW   = ATW;
    localparam int DW2  = DETW + 1;
    localparam int NUMW = 3 * CW + 31;

    // prep stage 0
    logic              r0_vld;
    t_side             r0_side;
    logic              r0_deg;
    logic [DETW-1:0]   r0_d;
    logic [MW-1:0]     r0_mag [NLANE];
    logic [NLANE-1:0]  r0_neg;
    logic [MW-1:0]     n_mag [NLANE];
    logic [NLANE-1:0]  n_neg;

    // step stages
    logic [OUT_W:0]    r_vld;
    t_side             r_side [OUT_W+1];
    logic              r_deg [OUT_W+1];
    logic [NLANE-1:0]  r_neg [OUT_W+1];
    logic [NLANE-1:0]  r_big [OUT_W+1];
    logic [DW2-1:0]    r_d2 [OUT_W+1];
    logic [DW2-1:0]    r_rem [OUT_W+1][NLANE];
    logic [OUT_W-1:0]  r_lo [OUT_W+1][NLANE];
    logic [OUT_W-1:0]  r_q [OUT_W+1][NLANE];

    logic              r_ov;
    t_out              r_row;
    logic [OUT_W-1:0]  w_res [NLANE];

    always_comb begin
        logic [GW-1:0]  gm;
        logic [ATW-1:0] am;
        for (int k = 0; k < 3; k++) begin
            gm = i_g[k][GW-1] ? GW'(-i_g[k]) : GW'(i_g[k]);
            n_mag[k] = MW'(gm);
            n_neg[k] = i_g[k][GW-1] ^ i_det[DETW-1];
        end
        am = i_a[ATW-1] ? ATW'(-i_a) : ATW'(i_a);
        n_mag[LANE_C] = MW'(am);
        n_neg[LANE_C] = (!i_a[ATW-1] && (i_a != '0)) ^ i_det[DETW-1];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_side <= i_side;
            r0_deg  <= (i_det == '0);
            r0_d    <= i_det[DETW-1] ? DETW'(-i_det) : DETW'(i_det);
            r0_mag  <= n_mag;
            r0_neg  <= n_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r_vld  <= '0;
            r_ov   <= 1'b0;
        end else if (i_en) begin
            r0_vld <= i_valid;
            r_vld  <= {r_vld[OUT_W-1:0], r0_vld};
            r_ov   <= r_vld[OUT_W];
        end
    end

    // stage 1: rounding numerator 2n+d over divisor 2d, overflow check
    always_ff @(posedge i_clk) begin
        logic [NUMW-1:0] num;
        logic [DW2-1:0]  d2;
        if (i_en) begin
            d2 = {r0_d, 1'b0};
            r_side[0] <= r0_side;
            r_deg[0]  <= r0_deg;
            r_neg[0]  <= r0_neg;
            r_d2[0]   <= d2;
            for (int k = 0; k < NLANE; k++) begin
                if (k == LANE_C) begin
                    num = (NUMW'(r0_mag[k]) << (OUT_FRAC + 1)) + NUMW'(r0_d);
                end else begin
                    num = (NUMW'(r0_mag[k]) << (GRAD_SH + 1)) + NUMW'(r0_d);
                end
                r_big[0][k] <= DW2'(num[NUMW-1:OUT_W]) >= d2;
                r_rem[0][k] <= DW2'(num[NUMW-1:OUT_W]);
                r_lo[0][k]  <= num[OUT_W-1:0];
                r_q[0][k]   <= '0;
            end
        end
    end

    for (genvar s = 0; s < OUT_W; s++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[s+1] <= r_side[s];
                r_deg[s+1]  <= r_deg[s];
                r_neg[s+1]  <= r_neg[s];
                r_big[s+1]  <= r_big[s];
                r_d2[s+1]   <= r_d2[s];
            end
        end
        for (genvar k = 0; k < NLANE; k++) begin : g_lane
            logic [DW2:0] t;
            logic         ge;
            assign t  = {r_rem[s][k], r_lo[s][k][OUT_W-1]};
            assign ge = (t >= {1'b0, r_d2[s]});
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s+1][k] <= ge ? DW2'(t - {1'b0, r_d2[s]}) : t[DW2-1:0];
                    r_lo[s+1][k]  <= {r_lo[s][k][OUT_W-2:0], 1'b0};
                    r_q[s+1][k]   <= {r_q[s][k][OUT_W-2:0], ge};
                end
            end
        end
    end

    always_comb begin
        logic [OUT_W-1:0] lim;
        logic [OUT_W-1:0] mag;
        for (int k = 0; k < NLANE; k++) begin
            lim = r_neg[OUT_W][k] ? SAT_NEG : SAT_POS;
            mag = r_q[OUT_W][k];
            if (r_big[OUT_W][k] || (mag > lim)) mag = lim;
            w_res[k] = r_neg[OUT_W][k] ? -mag : mag;
            if (r_deg[OUT_W]) w_res[k] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_row.vertex_sel <= r_side[OUT_W].vsel;
            r_row.last       <= r_side[OUT_W].last;
            r_row.degenerate <= r_deg[OUT_W];
            r_row.grad_x     <= w_res[0];
            r_row.grad_y     <= w_res[1];
            r_row.grad_z     <= w_res[2];
            r_row.const_term <= w_res[LANE_C];
        end
    end

    assign o_valid = r_ov;
    assign o_row   = r_row;

endmodule
